### design/chd_pkg.sv
`default_nettype none
// Shared types, widths and command codes of the canonical Huffman decoder.
package chd_pkg;

    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int NUM_SYMBOLS_DEF  = 256;

    localparam int LEN_W       = 6;
    localparam int SYM_W       = 8;
    localparam int CNT_W       = 9;
    localparam int WORD_W      = 32;
    localparam int MSG_W       = 40;
    localparam int BUF_W       = 64;
    localparam int FILL_W      = 7;
    localparam int MAX_RESULTS = 32;
    localparam int NRES_W      = 6;

    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_LOAD     = 2'd0;
    localparam t_cmd CMD_FINALIZE = 2'd1;
    localparam t_cmd CMD_DATA     = 2'd2;

endpackage
`default_nettype wire

### design/canonical_huffman_decoder_unit.sv
`default_nettype none
// Top level of the canonical Huffman decoder.
//
// A length load or an ignored command is taken in the idle state. A finalize
// sweeps the length memory twice (count, then placement of symbols) and the
// length table twice (start values, first slots); the input is stalled
// meanwhile. A data word is taken in the idle state; then each decoded symbol
// passes a table search in ST_DEC, which issues the read of the sorted-symbol
// memory, and the output load in ST_EMIT, where a stalled output register
// waits. A closing search ends the word. The registered read of the symbol
// memory is why each symbol needs both states. One item is worked on at a time.
module canonical_huffman_decoder_unit #(
    parameter int MAX_CODE_LEN = chd_pkg::MAX_CODE_LEN_DEF,
    parameter int NUM_SYMBOLS  = chd_pkg::NUM_SYMBOLS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [chd_pkg::MSG_W-1:0] i_cfg_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [1:0]                i_cmd,
    input  wire logic [chd_pkg::SYM_W-1:0] i_symbol,
    input  wire logic [chd_pkg::LEN_W-1:0] i_code_len,
    input  wire logic [chd_pkg::WORD_W-1:0] i_data_word,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [chd_pkg::SYM_W-1:0]      o_decoded_symbol,
    output logic                           o_last_of_run,
    output logic                           o_message_done
);

    import chd_pkg::*;

    localparam int AW   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int KW   = $clog2(NUM_SYMBOLS + 1);
    localparam int LI_W = $clog2(MAX_CODE_LEN + 1);
    localparam int CW   = (MAX_CODE_LEN > CNT_W) ? MAX_CODE_LEN : CNT_W;
    localparam int SW   = MAX_CODE_LEN + CNT_W + 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_COUNT  = 3'd1;
    localparam logic [2:0] ST_STARTS = 3'd2;
    localparam logic [2:0] ST_SLOTS  = 3'd3;
    localparam logic [2:0] ST_PLACE  = 3'd4;
    localparam logic [2:0] ST_DEC    = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    logic [2:0]              r_state;
    logic [MSG_W-1:0]        r_msg_bits;
    logic [NUM_SYMBOLS-1:0]  r_len_vld;
    logic [CNT_W-1:0]        r_cnt  [MAX_CODE_LEN+1];
    logic [MAX_CODE_LEN-1:0] r_aln  [MAX_CODE_LEN+1];
    logic [CNT_W-1:0]        r_fst  [MAX_CODE_LEN+1];
    logic [CNT_W-1:0]        r_nxt  [MAX_CODE_LEN+1];
    logic [BUF_W-1:0]        r_buf;
    logic [FILL_W-1:0]       r_fill;
    logic [MSG_W-1:0]        r_rem;
    logic [NRES_W-1:0]       r_nres;
    logic [KW-1:0]           r_k;
    logic [AW-1:0]           r_sq;
    logic                    r_rd_pend;
    logic                    r_lv_q;
    logic [LI_W-1:0]         r_j;
    logic [CNT_W:0]          r_start;
    logic [CNT_W-1:0]        r_acc;
    logic                    r_out_valid;
    logic [SYM_W-1:0]        r_out_sym;
    logic                    r_out_last;
    logic                    r_out_done;

    logic                    in_acc;
    logic                    out_free;
    logic                    emit_load;
    logic                    len_we;
    logic [AW-1:0]           len_waddr;
    logic [LEN_W-1:0]        len_wdata;
    logic                    len_re;
    logic [LEN_W-1:0]        len_rdata;
    logic [LEN_W-1:0]        len_q;
    logic                    sym_we;
    logic [AW-1:0]           sym_waddr;
    logic                    sym_re;
    logic [AW-1:0]           sym_raddr;
    logic [SYM_W-1:0]        sym_rdata;

    logic [MAX_CODE_LEN-1:0] win;
    logic [LI_W-1:0]         found;
    logic [MAX_CODE_LEN-1:0] diff;
    logic [MAX_CODE_LEN-1:0] idx;
    logic                    idx_ok;
    logic                    fits;
    logic                    more;
    logic                    dec_cont;
    logic                    dec_abort;
    logic [SYM_W-1:0]        slot;
    logic [CNT_W:0]          nxt_start;
    logic [LI_W-1:0]         up_j;
    logic [SW-1:0]           aln_wide;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign emit_load = (r_state == ST_EMIT) && out_free;

    // Length memory: written by loads, swept by finalize.
    assign len_we    = in_acc && (t_cmd'(i_cmd) == CMD_LOAD)
                       && ({1'b0, i_symbol} < (SYM_W+1)'(NUM_SYMBOLS));
    assign len_waddr = i_symbol[AW-1:0];
    assign len_wdata = (i_code_len > LEN_W'(MAX_CODE_LEN)) ? '0 : i_code_len;
    assign len_re    = ((r_state == ST_COUNT) || (r_state == ST_PLACE))
                       && (r_k != KW'(NUM_SYMBOLS));
    assign len_q     = r_lv_q ? len_rdata : '0;

    chd_ram #(.WIDTH(LEN_W), .DEPTH(NUM_SYMBOLS), .AW(AW)) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_re    (len_re),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (len_rdata)
    );

    // Sorted-symbol memory: filled by the placement sweep, read while decoding.
    assign sym_we    = (r_state == ST_PLACE) && r_rd_pend && (len_q != '0);
    assign sym_waddr = r_nxt[len_q[LI_W-1:0]][AW-1:0];
    assign sym_re    = (r_state == ST_DEC) && dec_cont;
    assign sym_raddr = slot[AW-1:0];

    chd_ram #(.WIDTH(SYM_W), .DEPTH(NUM_SYMBOLS), .AW(AW)) u_sym_ram (
        .i_clk   (i_clk),
        .i_we    (sym_we),
        .i_waddr (sym_waddr),
        .i_wdata (SYM_W'(r_sq)),
        .i_re    (sym_re),
        .i_raddr (sym_raddr),
        .o_rdata (sym_rdata)
    );

    // Table search over the window of the next code bits.
    assign win = r_buf[BUF_W-1 -: MAX_CODE_LEN];

    always_comb begin
        found = '0;
        for (int l = MAX_CODE_LEN; l >= 1; l--) begin
            if ((r_cnt[l] != '0) && (r_aln[l] <= win)) begin
                found = LI_W'(l);
            end
        end
    end

    assign diff   = win - r_aln[found];
    assign idx    = diff >> (LI_W'(MAX_CODE_LEN) - found);
    assign idx_ok = CW'(idx) < CW'(r_cnt[found]);
    assign fits   = FILL_W'(found) <= r_fill;
    assign more   = (r_nres < NRES_W'(MAX_RESULTS)) && (r_rem != '0);
    assign dec_cont  = more && (found != '0) && fits && idx_ok;
    assign dec_abort = more && ((found == '0) || (fits && !idx_ok));
    assign slot      = r_fst[found][SYM_W-1:0] + idx[SYM_W-1:0];

    // Start values run from the longest length down.
    assign up_j      = (r_j == LI_W'(MAX_CODE_LEN)) ? r_j : r_j + LI_W'(1);
    assign nxt_start = (r_start + ((r_j == LI_W'(MAX_CODE_LEN)) ? '0
                       : (CNT_W+1)'(r_cnt[up_j]))) >> 1;
    assign aln_wide  = SW'(nxt_start) << (LI_W'(MAX_CODE_LEN) - r_j);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_msg_bits  <= '0;
            r_len_vld   <= '0;
            r_buf       <= '0;
            r_fill      <= '0;
            r_rem       <= '0;
            r_nres      <= '0;
            r_k         <= '0;
            r_rd_pend   <= 1'b0;
            r_lv_q      <= 1'b0;
            r_j         <= '0;
            r_start     <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            for (int l = 0; l <= MAX_CODE_LEN; l++) begin
                r_cnt[l] <= '0;
                r_aln[l] <= '0;
                r_fst[l] <= '0;
                r_nxt[l] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_msg_bits <= i_cfg_data;
            end
            if (len_we) begin
                r_len_vld[len_waddr] <= 1'b1;
            end
            if (len_re) begin
                r_lv_q <= r_len_vld[r_k[AW-1:0]];
                r_sq   <= r_k[AW-1:0];
            end
            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && (t_cmd'(i_cmd) == CMD_FINALIZE)) begin
                        for (int l = 0; l <= MAX_CODE_LEN; l++) begin
                            r_cnt[l] <= '0;
                        end
                        r_buf     <= '0;
                        r_fill    <= '0;
                        r_rem     <= r_msg_bits;
                        r_k       <= '0;
                        r_rd_pend <= 1'b0;
                        r_state   <= ST_COUNT;
                    end else if (in_acc && (t_cmd'(i_cmd) == CMD_DATA)
                                 && (r_rem != '0)
                                 && (r_fill <= FILL_W'(WORD_W))) begin
                        r_buf   <= r_buf | (BUF_W'(i_data_word)
                                   << (FILL_W'(WORD_W) - r_fill));
                        r_fill  <= r_fill + FILL_W'(WORD_W);
                        r_nres  <= '0;
                        r_state <= ST_DEC;
                    end
                end
                ST_COUNT: begin
                    r_rd_pend <= len_re;
                    if (len_re) begin
                        r_k <= r_k + KW'(1);
                    end
                    if (r_rd_pend) begin
                        r_cnt[len_q[LI_W-1:0]] <= r_cnt[len_q[LI_W-1:0]] + CNT_W'(1);
                    end
                    if (!len_re && !r_rd_pend) begin
                        r_j     <= LI_W'(MAX_CODE_LEN);
                        r_start <= '0;
                        r_state <= ST_STARTS;
                    end
                end
                ST_STARTS: begin
                    r_aln[r_j] <= aln_wide[MAX_CODE_LEN-1:0];
                    r_start    <= nxt_start;
                    if (r_j == LI_W'(1)) begin
                        r_acc   <= '0;
                        r_state <= ST_SLOTS;
                    end else begin
                        r_j <= r_j - LI_W'(1);
                    end
                end
                ST_SLOTS: begin
                    r_fst[r_j] <= r_acc;
                    r_nxt[r_j] <= r_acc;
                    r_acc      <= r_acc + r_cnt[r_j];
                    if (r_j == LI_W'(MAX_CODE_LEN)) begin
                        r_k       <= '0;
                        r_rd_pend <= 1'b0;
                        r_state   <= ST_PLACE;
                    end else begin
                        r_j <= r_j + LI_W'(1);
                    end
                end
                ST_PLACE: begin
                    r_rd_pend <= len_re;
                    if (len_re) begin
                        r_k <= r_k + KW'(1);
                    end
                    if (sym_we) begin
                        r_nxt[len_q[LI_W-1:0]] <= r_nxt[len_q[LI_W-1:0]] + CNT_W'(1);
                    end
                    if (!len_re && !r_rd_pend) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_DEC: begin
                    if (dec_cont) begin
                        r_buf   <= r_buf << found;
                        r_fill  <= r_fill - FILL_W'(found);
                        r_rem   <= (MSG_W'(found) >= r_rem) ? '0 : r_rem - MSG_W'(found);
                        r_nres  <= r_nres + NRES_W'(1);
                        r_state <= ST_EMIT;
                    end else begin
                        if (dec_abort) begin
                            r_buf  <= '0;
                            r_fill <= '0;
                            r_rem  <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    // The search already sees the next code, so the last
                    // symbol of this word is known when it is loaded.
                    if (emit_load) begin
                        r_out_sym   <= sym_rdata;
                        r_out_last  <= !dec_cont;
                        r_out_done  <= (r_rem == '0);
                        r_state     <= ST_DEC;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall       = (r_state != ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_decoded_symbol = r_out_sym;
    assign o_last_of_run    = r_out_last;
    assign o_message_done   = r_out_done;

endmodule
`default_nettype wire

### design/chd_ram.sv
`default_nettype none
// Generic single-write, single-read RAM with a registered read port.
module chd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### design/chd_checker.sv
`default_nettype none
// Port-level checker of the canonical Huffman decoder and its bind.
module chd_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_in_stall,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_stall,
    input wire logic [chd_pkg::SYM_W-1:0] o_decoded_symbol,
    input wire logic                      o_last_of_run,
    input wire logic                      o_message_done
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_decoded_symbol))
        else $error("stalled output transaction changed");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_message_done |-> o_last_of_run)
        else $error("message end not marked as last of run");

    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !$isunknown({o_decoded_symbol, o_last_of_run, o_message_done}))
        else $error("output transaction carries unknown bits");

    a_busy_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_run |-> o_in_stall)
        else $error("input taken in the middle of a run");

endmodule

bind canonical_huffman_decoder_unit chd_checker u_chd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_decoded_symbol (o_decoded_symbol),
    .o_last_of_run    (o_last_of_run),
    .o_message_done   (o_message_done)
);
`default_nettype wire
